>>> rtl/cic_pkg.sv
// ----------------------------------------------------------------------------
// cic_pkg
// shared constants and types for the column information content unit
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int MAX_LETTERS_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int LETTER_W = 8;
    localparam int ALPHA_W  = 6;
    localparam int DIVR_W   = 16;
    localparam int TOTAL_W  = 21;
    localparam int ENT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int KCONST_W = 32;

    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = ALPHA_W'(20);
    localparam logic [DIVR_W-1:0]   DIVR_RESET  = DIVR_W'(1);
    localparam logic [KCONST_W-1:0] ERR_K       = 32'd3098164009;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECT  = 2'd2;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_sort_ctl;

endpackage

>>> rtl/cic_divider.sv
// ----------------------------------------------------------------------------
// cic_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module cic_divider import cic_pkg::*; #(
    parameter int NW = 38,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    r_q;
    logic [DW:0]      r_r;
    logic [DW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DW:0]      n_r2;
    logic             n_ge;

    assign n_r2 = {r_r[DW-1:0], r_q[NW-1]};
    assign n_ge = n_r2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            r_r <= n_ge ? (n_r2 - {1'b0, r_d}) : n_r2;
            r_q <= {r_q[NW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> rtl/cic_log2.sv
// ----------------------------------------------------------------------------
// cic_log2
// fixed point log2 by repeated squaring, one fraction bit per cycle
// ----------------------------------------------------------------------------
module cic_log2 import cic_pkg::*; #(
    parameter int IN_W      = 17,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [IN_W-1:0]                     i_x,
    output logic                                o_done,
    output logic [$clog2(IN_W)+FRAC_BITS-1:0]   o_result
);
    localparam int E_W   = $clog2(IN_W);
    localparam int CNT_W = $clog2(FRAC_BITS);

    logic [E_W-1:0]       n_e;
    logic [31:0]          n_norm;
    logic [63:0]          n_sq;
    logic [E_W-1:0]       r_e;
    logic [31:0]          r_m;
    logic [FRAC_BITS-1:0] r_frac;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    always_comb begin
        n_e = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (i_x[i]) begin
                n_e = E_W'(i);
            end
        end
        n_norm = 32'(i_x) << (5'd31 - 5'(n_e));
    end

    assign n_sq = 64'(r_m) * 64'(r_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_e    <= n_e;
            r_m    <= n_norm;
            r_frac <= '0;
        end else if (r_busy) begin
            r_m    <= n_sq[63] ? n_sq[63:32] : n_sq[62:31];
            r_frac <= {r_frac[FRAC_BITS-2:0], n_sq[63]};
        end
    end

    assign o_done   = r_done;
    assign o_result = {r_e, r_frac};
endmodule

>>> rtl/cic_cell.sv
// ----------------------------------------------------------------------------
// cic_cell
// one cell of the insertion sort chain, holds one entry
// ----------------------------------------------------------------------------
module cic_cell import cic_pkg::*; #(
    parameter int EW = 44,
    parameter int IW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_sort_ctl     i_ctl,
    input  logic [EW-1:0] i_new,
    input  logic          i_prev_keep,
    input  logic          i_prev_valid,
    input  logic [EW-1:0] i_prev,
    input  logic          i_next_valid,
    input  logic [EW-1:0] i_next,
    output logic          o_valid,
    output logic [EW-1:0] o_entry,
    output logic          o_keep
);
    logic          r_valid;
    logic [EW-1:0] r_entry;

    // equal keys stay in front of the newcomer
    assign o_keep = r_valid && (r_entry[EW-1 -: IW] <= i_new[EW-1 -: IW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && !o_keep) begin
            r_valid <= i_prev_keep ? 1'b1 : i_prev_valid;
        end else if (i_ctl.shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && !o_keep) begin
            r_entry <= i_prev_keep ? i_new : i_prev;
        end else if (i_ctl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
endmodule

>>> rtl/cic_sorter.sv
// ----------------------------------------------------------------------------
// cic_sorter
// chain of sort cells, ascending by key, drained from the head
// ----------------------------------------------------------------------------
module cic_sorter import cic_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int EW    = 44,
    parameter int IW    = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_sort_ctl     i_ctl,
    input  logic [EW-1:0] i_new,
    output logic          o_head_valid,
    output logic [EW-1:0] o_head
);
    logic          w_valid [DEPTH];
    logic [EW-1:0] w_entry [DEPTH];
    logic          w_keep  [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic          w_pkeep;
        logic          w_pvalid;
        logic [EW-1:0] w_prev;
        logic          w_nvalid;
        logic [EW-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_pkeep  = 1'b1;
            assign w_pvalid = 1'b0;
            assign w_prev   = '0;
        end else begin : g_mid
            assign w_pkeep  = w_keep[g-1];
            assign w_pvalid = w_valid[g-1];
            assign w_prev   = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_nvalid = 1'b0;
            assign w_next   = '0;
        end else begin : g_body
            assign w_nvalid = w_valid[g+1];
            assign w_next   = w_entry[g+1];
        end

        cic_cell #(.EW(EW), .IW(IW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_new        (i_new),
            .i_prev_keep  (w_pkeep),
            .i_prev_valid (w_pvalid),
            .i_prev       (w_prev),
            .i_next_valid (w_nvalid),
            .i_next       (w_next),
            .o_valid      (w_valid[g]),
            .o_entry      (w_entry[g]),
            .o_keep       (w_keep[g])
        );
    end

    assign o_head_valid = w_valid[0];
    assign o_head       = w_entry[0];
endmodule

>>> rtl/column_information_content_unit.sv
// ----------------------------------------------------------------------------
// column_information_content_unit
// information content of one alignment column, letters sorted by information
// ----------------------------------------------------------------------------
// One letter at a time is taken. A stored letter passes through the serial
// divider, then through the squaring log2 unit and the accumulate step when
// its fraction is nonzero, then an advance step and the ready state before the
// next transfer. At the column end the log2 of the alphabet is taken, the
// correction term takes one more divider pass when enabled and the total
// is nonzero, each held letter is then read, weighed and put into the sort
// chain, and the sorted results leave at one per cycle while the output is
// ready. Input is not taken while a column is being finished or emitted.
module column_information_content_unit import cic_pkg::*; #(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // letter, letter_count
    input  logic [((LETTER_W+COUNT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // column_end
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_letter, fraction, information
    output logic [((LETTER_W+2*FRAC_BITS+4+7)/8)*8-1:0] m_axis_tdata,
    // last_of_column
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int CW     = COUNT_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int FW     = F + 1;
    localparam int IW     = F + 3;
    localparam int EW     = LETTER_W + FW + IW;
    localparam int IN_DW  = ((LETTER_W + CW + 7) / 8) * 8;
    localparam int OUT_DW = ((EW + 7) / 8) * 8;
    localparam int NW     = (CW + F > ALPHA_W + KCONST_W) ? CW + F : ALPHA_W + KCONST_W;
    localparam int DW     = TOTAL_W;
    localparam int LIN_W  = (FW > ALPHA_W) ? FW : ALPHA_W;
    localparam int LG_W   = $clog2(LIN_W) + F;
    localparam int TW     = NW + 2;
    localparam int IDX_W  = $clog2(MAX_LETTERS);
    localparam int HW     = $clog2(MAX_LETTERS + 1);
    localparam int TS_W   = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;
    localparam int EP_W   = FW + LG_W;
    localparam int IP_W   = FW + IW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FDIV = 4'd1;
    localparam logic [3:0] S_FLOG = 4'd2;
    localparam logic [3:0] S_FACC = 4'd3;
    localparam logic [3:0] S_NEXT = 4'd4;
    localparam logic [3:0] S_END  = 4'd5;
    localparam logic [3:0] S_ALOG = 4'd6;
    localparam logic [3:0] S_EDIV = 4'd7;
    localparam logic [3:0] S_IRD  = 4'd8;
    localparam logic [3:0] S_IMUL = 4'd9;
    localparam logic [3:0] S_IINS = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic [NW-1:0] ONE_Q  = NW'(1) << F;
    localparam logic [LG_W-1:0] MAXLG = LG_W'(F) << F;

    logic [ALPHA_W-1:0] r_alpha;
    logic [DIVR_W-1:0]  r_divr;
    logic               r_corr;

    logic [3:0]          r_state;
    logic [LETTER_W-1:0] r_letter;
    logic [CW-1:0]       r_count;
    logic                r_last;
    logic [FW-1:0]       r_frac;
    logic [HW-1:0]       r_held;
    logic [TOTAL_W-1:0]  r_total;
    logic [ENT_W-1:0]    r_ent;
    logic [EP_W-1:0]     r_eprod;
    logic signed [TW-1:0] r_tinfo;
    logic [IW-1:0]       r_tpos;
    logic [IP_W-1:0]     r_iprod;
    logic [IDX_W-1:0]    r_idx;
    logic [HW-1:0]       r_left;

    logic [LETTER_W-1:0] r_mem_letter [MAX_LETTERS];
    logic [FW-1:0]       r_mem_frac   [MAX_LETTERS];
    logic [LETTER_W-1:0] r_rd_letter;
    logic [FW-1:0]       r_rd_frac;

    logic                n_accept;
    logic                n_out_xfer;
    logic [ALPHA_W-1:0]  n_alpha;
    logic [DIVR_W-1:0]   n_divr;
    logic                n_div_start;
    logic [NW-1:0]       n_div_num;
    logic [DW-1:0]       n_div_den;
    logic                w_div_done;
    logic [NW-1:0]       w_quot;
    logic                n_log_start;
    logic [LIN_W-1:0]    n_log_x;
    logic                w_log_done;
    logic [LG_W-1:0]     w_lg;
    logic [FW-1:0]       n_fsat;
    logic [TS_W-1:0]     n_tsum;
    logic [ENT_W:0]      n_esum;
    logic [IP_W-F-1:0]   n_ishift;
    logic [IW-1:0]       n_info;
    t_sort_ctl           n_sctl;
    logic [EW-1:0]       n_new;
    logic                w_head_valid;
    logic [EW-1:0]       w_head;

    assign n_accept   = s_axis_tvalid && s_axis_tready;
    assign n_out_xfer = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT) && w_head_valid;
    assign m_axis_tlast  = (r_left == HW'(1));
    assign m_axis_tdata  = OUT_DW'(w_head);

    assign n_alpha = (r_alpha == '0) ? ALPHA_W'(1) : r_alpha;
    assign n_divr  = (r_divr == '0) ? DIVR_W'(1) : r_divr;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
            r_divr  <= DIVR_RESET;
            r_corr  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ALPHABET: r_alpha <= i_cfg_data[ALPHA_W-1:0];
                REG_DIVISOR:  r_divr  <= i_cfg_data[DIVR_W-1:0];
                REG_CORRECT:  r_corr  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // shared divider and log2 unit
    always_comb begin
        n_div_start = 1'b0;
        n_div_num   = NW'({s_axis_tdata[LETTER_W +: CW], F'(0)});
        n_div_den   = DW'(n_divr);
        if (r_state == S_IDLE) begin
            n_div_start = n_accept && (r_held < HW'(MAX_LETTERS));
        end else if (r_state == S_ALOG) begin
            n_div_start = w_log_done && r_corr && (r_total != '0);
            n_div_num   = NW'(n_alpha - ALPHA_W'(1)) * NW'(ERR_K);
            n_div_den   = r_total;
        end
    end

    assign n_fsat = (w_quot > ONE_Q) ? FW'(ONE_Q) : w_quot[FW-1:0];

    always_comb begin
        n_log_start = 1'b0;
        n_log_x     = LIN_W'(n_fsat);
        if (r_state == S_FDIV) begin
            n_log_start = w_div_done && (n_fsat != '0);
        end else if (r_state == S_END) begin
            n_log_start = (r_held != '0);
            n_log_x     = LIN_W'(n_alpha);
        end
    end

    cic_divider #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    cic_log2 #(.IN_W(LIN_W), .FRAC_BITS(F)) u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_log_start),
        .i_x      (n_log_x),
        .o_done   (w_log_done),
        .o_result (w_lg)
    );

    assign n_tsum   = TS_W'(r_total) + TS_W'(r_count);
    assign n_esum   = (ENT_W+1)'(r_ent) + (ENT_W+1)'(r_eprod >> F);
    assign n_ishift = r_iprod[IP_W-1:F];
    assign n_info   = (n_ishift > (IP_W-F)'({IW{1'b1}})) ? {IW{1'b1}} : n_ishift[IW-1:0];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_total <= '0;
            r_ent   <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_last <= s_axis_tlast;
                        if (r_held < HW'(MAX_LETTERS)) begin
                            r_state <= S_FDIV;
                        end else if (s_axis_tlast) begin
                            r_state <= S_END;
                        end
                    end
                end
                S_FDIV: begin
                    if (w_div_done) begin
                        r_held  <= r_held + 1'b1;
                        r_total <= (n_tsum > TS_W'({TOTAL_W{1'b1}})) ?
                                   {TOTAL_W{1'b1}} : n_tsum[TOTAL_W-1:0];
                        r_state <= (n_fsat != '0) ? S_FLOG : S_NEXT;
                    end
                end
                S_FLOG: begin
                    if (w_log_done) begin
                        r_state <= S_FACC;
                    end
                end
                S_FACC: begin
                    r_ent   <= n_esum[ENT_W] ? {ENT_W{1'b1}} : n_esum[ENT_W-1:0];
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_state <= r_last ? S_END : S_IDLE;
                end
                S_END: begin
                    r_idx <= '0;
                    if (r_held == '0) begin
                        r_total <= '0;
                        r_ent   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ALOG;
                    end
                end
                S_ALOG: begin
                    if (w_log_done) begin
                        r_state <= (r_corr && (r_total != '0)) ? S_EDIV : S_IRD;
                    end
                end
                S_EDIV: begin
                    if (w_div_done) begin
                        r_state <= S_IRD;
                    end
                end
                S_IRD: begin
                    r_state <= S_IMUL;
                end
                S_IMUL: begin
                    r_state <= S_IINS;
                end
                S_IINS: begin
                    r_idx <= r_idx + 1'b1;
                    if (HW'(r_idx) + HW'(1) == r_held) begin
                        r_left  <= r_held;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_IRD;
                    end
                end
                S_OUT: begin
                    if (n_out_xfer) begin
                        r_left <= r_left - 1'b1;
                        if (r_left == HW'(1)) begin
                            r_held  <= '0;
                            r_total <= '0;
                            r_ent   <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_letter <= s_axis_tdata[LETTER_W-1:0];
            r_count  <= s_axis_tdata[LETTER_W +: CW];
        end
        if ((r_state == S_FDIV) && w_div_done) begin
            r_frac <= n_fsat;
            r_mem_letter[r_held[IDX_W-1:0]] <= r_letter;
            r_mem_frac[r_held[IDX_W-1:0]]   <= n_fsat;
        end
        if ((r_state == S_FLOG) && w_log_done) begin
            r_eprod <= EP_W'(r_frac) * EP_W'(MAXLG - w_lg);
        end
        if ((r_state == S_ALOG) && w_log_done) begin
            r_tinfo <= $signed(TW'(w_lg)) - $signed(TW'(r_ent));
        end
        if ((r_state == S_EDIV) && w_div_done) begin
            r_tinfo <= r_tinfo - $signed(TW'(w_quot >> (KCONST_W - F)));
        end
        if (r_state == S_IRD) begin
            r_tpos <= (r_tinfo > 0) ? r_tinfo[IW-1:0] : '0;
        end
        if (r_state == S_IMUL) begin
            r_iprod <= IP_W'(r_rd_frac) * IP_W'(r_tpos);
        end
        r_rd_letter <= r_mem_letter[r_idx];
        r_rd_frac   <= r_mem_frac[r_idx];
    end

    assign n_sctl.insert = (r_state == S_IINS);
    assign n_sctl.shift  = n_out_xfer;
    assign n_new = {n_info, r_rd_frac, r_rd_letter};

    cic_sorter #(.DEPTH(MAX_LETTERS), .EW(EW), .IW(IW)) u_sort (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (n_sctl),
        .i_new        (n_new),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );
endmodule
